/* hdl/ac3sh_pkg.sv */
// ----------------------------------------------------------------------------
// ac3sh_pkg
// Types, constants and decode tables for the AC-3 sync header finder.
// ----------------------------------------------------------------------------
package ac3sh_pkg;

	localparam int WIN    = 7;
	localparam int QDEPTH = 2;

	localparam logic [7:0]  SYNC_HI    = 8'h0B;
	localparam logic [7:0]  SYNC_LO    = 8'h77;
	localparam logic [7:0]  BSID_LIMIT = 8'h60;
	localparam logic [5:0]  FSC_LIMIT  = 6'd38;
	localparam logic [1:0]  FS_BAD     = 2'b11;
	localparam logic [1:0]  FS_48K     = 2'b00;
	localparam logic [1:0]  FS_44K     = 2'b01;
	localparam logic [7:0]  DSUR_MASK  = 8'hF8;
	localparam logic [7:0]  DSUR_CODE  = 8'h50;
	localparam logic [15:0] OFFS_MAX   = 16'hFFFF;
	localparam logic [15:0] SR_48K     = 16'd48000;
	localparam logic [15:0] SR_44K     = 16'd44100;
	localparam logic [15:0] SR_32K     = 16'd32000;
	localparam logic [2:0]  DSUR_CH    = 3'd2;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_FSC   = 2'd1,
		ST_BAD_FS    = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// classified event passed from the front end to the decoder
	typedef struct packed {
		status_t     status;
		logic [15:0] sync_offset;
		logic [7:0]  b4;
		logic [7:0]  b5;
		logic [7:0]  b6;
	} hdr_evt_t;

	function automatic logic [9:0] rate_kbps(input logic [4:0] idx);
		logic [9:0] r;
		case (idx)
			5'd0:    r = 10'd32;
			5'd1:    r = 10'd40;
			5'd2:    r = 10'd48;
			5'd3:    r = 10'd56;
			5'd4:    r = 10'd64;
			5'd5:    r = 10'd80;
			5'd6:    r = 10'd96;
			5'd7:    r = 10'd112;
			5'd8:    r = 10'd128;
			5'd9:    r = 10'd160;
			5'd10:   r = 10'd192;
			5'd11:   r = 10'd224;
			5'd12:   r = 10'd256;
			5'd13:   r = 10'd320;
			5'd14:   r = 10'd384;
			5'd15:   r = 10'd448;
			5'd16:   r = 10'd512;
			5'd17:   r = 10'd576;
			5'd18:   r = 10'd640;
			default: r = 10'd0;
		endcase
		return r;
	endfunction

	// bit rate in bits per second
	function automatic logic [19:0] rate_bps(input logic [4:0] idx);
		logic [19:0] r;
		case (idx)
			5'd0:    r = 20'd32000;
			5'd1:    r = 20'd40000;
			5'd2:    r = 20'd48000;
			5'd3:    r = 20'd56000;
			5'd4:    r = 20'd64000;
			5'd5:    r = 20'd80000;
			5'd6:    r = 20'd96000;
			5'd7:    r = 20'd112000;
			5'd8:    r = 20'd128000;
			5'd9:    r = 20'd160000;
			5'd10:   r = 20'd192000;
			5'd11:   r = 20'd224000;
			5'd12:   r = 20'd256000;
			5'd13:   r = 20'd320000;
			5'd14:   r = 20'd384000;
			5'd15:   r = 20'd448000;
			5'd16:   r = 20'd512000;
			5'd17:   r = 20'd576000;
			5'd18:   r = 20'd640000;
			default: r = 20'd0;
		endcase
		return r;
	endfunction

	// floor(320 * kbps / 147): 16-bit words per frame at 44.1 kHz
	function automatic logic [10:0] words_44k(input logic [4:0] idx);
		logic [10:0] r;
		case (idx)
			5'd0:    r = 11'd69;
			5'd1:    r = 11'd87;
			5'd2:    r = 11'd104;
			5'd3:    r = 11'd121;
			5'd4:    r = 11'd139;
			5'd5:    r = 11'd174;
			5'd6:    r = 11'd208;
			5'd7:    r = 11'd243;
			5'd8:    r = 11'd278;
			5'd9:    r = 11'd348;
			5'd10:   r = 11'd417;
			5'd11:   r = 11'd487;
			5'd12:   r = 11'd557;
			5'd13:   r = 11'd696;
			5'd14:   r = 11'd835;
			5'd15:   r = 11'd975;
			5'd16:   r = 11'd1114;
			5'd17:   r = 11'd1253;
			5'd18:   r = 11'd1393;
			default: r = 11'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] half_shift(input logic [3:0] bsid_hi);
		logic [1:0] r;
		case (bsid_hi)
			4'd9:    r = 2'd1;
			4'd10:   r = 2'd2;
			4'd11:   r = 2'd3;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] lfe_mask(input logic [2:0] acmod);
		logic [7:0] r;
		case (acmod)
			3'd0, 3'd1: r = 8'h10;
			3'd5, 3'd7: r = 8'h01;
			default:    r = 8'h04;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] mode_channels(input logic [2:0] acmod);
		logic [2:0] r;
		case (acmod)
			3'd0:    r = 3'd2;
			3'd1:    r = 3'd1;
			3'd2:    r = 3'd2;
			3'd3:    r = 3'd3;
			3'd4:    r = 3'd3;
			3'd5:    r = 3'd4;
			3'd6:    r = 3'd4;
			default: r = 3'd5;
		endcase
		return r;
	endfunction

endpackage

/* hdl/ac3sh_in_if.sv */
// ----------------------------------------------------------------------------
// ac3sh_in_if
// Byte stream channel: one buffer byte per transaction.
// ----------------------------------------------------------------------------
interface ac3sh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* hdl/ac3sh_out_if.sv */
// ----------------------------------------------------------------------------
// ac3sh_out_if
// Header report channel: one decoded header or status per transaction.
// ----------------------------------------------------------------------------
interface ac3sh_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] sync_offset;
	logic [19:0] stream_bps;
	logic [15:0] audio_hz;
	logic [11:0] frame_bytes;
	logic [2:0]  coding_mode;
	logic        has_lfe;
	logic        dolby_surround;
	logic [2:0]  channels;

	modport source (output valid, output status, output sync_offset, output stream_bps,
		output audio_hz, output frame_bytes, output coding_mode, output has_lfe,
		output dolby_surround, output channels, input ready);
	modport sink   (input valid, input status, input sync_offset, input stream_bps,
		input audio_hz, input frame_bytes, input coding_mode, input has_lfe,
		input dolby_surround, input channels, output ready);
endinterface

/* hdl/ac3sh_front.sv */
// ----------------------------------------------------------------------------
// ac3sh_front
// Byte window, sync search and event classification.
// ----------------------------------------------------------------------------
module ac3sh_front #(
	parameter int MAX_BUFFER = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ac3sh_in_if.sink             byte_ch,
	input  logic                 full,
	output logic                 push,
	output ac3sh_pkg::hdr_evt_t  evt
);
	import ac3sh_pkg::*;

	localparam int PW = $clog2(MAX_BUFFER + 1);

	// last six bytes, index WIN-2 is the newest
	logic [7:0]    hist_q [0:WIN-2];
	logic [PW-1:0] pos_q;
	logic          reported_q;

	logic          take;
	logic          in_room;
	logic          hit;
	logic          miss_end;
	logic [PW-1:0] offs_w;
	logic [31:0]   offs32;

	assign byte_ch.ready = !full;
	assign take          = byte_ch.valid && byte_ch.ready;
	assign in_room       = pos_q < PW'(MAX_BUFFER);

	always_comb begin
		offs_w   = pos_q - PW'(WIN - 1);
		offs32   = 32'(offs_w);
		hit      = in_room && !reported_q && (pos_q >= PW'(WIN - 1)) &&
			(hist_q[0] == SYNC_HI) && (hist_q[1] == SYNC_LO) &&
			(hist_q[WIN-2] < BSID_LIMIT);
		miss_end = byte_ch.last_byte && !reported_q && !hit;
		push     = take && (hit || miss_end);

		evt.b4   = hist_q[WIN-3];
		evt.b5   = hist_q[WIN-2];
		evt.b6   = byte_ch.data_byte;
		if (hit) begin
			evt.sync_offset = (offs32 > 32'(OFFS_MAX)) ? OFFS_MAX : offs32[15:0];
			if (hist_q[WIN-3][5:0] >= FSC_LIMIT) begin
				evt.status = ST_BAD_FSC;
			end else if (hist_q[WIN-3][7:6] == FS_BAD) begin
				evt.status = ST_BAD_FS;
			end else begin
				evt.status = ST_OK;
			end
		end else begin
			evt.sync_offset = '0;
			evt.status      = ST_NOT_FOUND;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_room) begin
			for (int i = 0; i < WIN - 2; i++) begin
				hist_q[i] <= hist_q[i+1];
			end
			hist_q[WIN-2] <= byte_ch.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			reported_q <= 1'b0;
		end else if (take) begin
			if (byte_ch.last_byte) begin
				pos_q      <= '0;
				reported_q <= 1'b0;
			end else begin
				if (in_room) pos_q <= pos_q + PW'(1);
				if (hit) reported_q <= 1'b1;
			end
		end
	end

endmodule

/* hdl/ac3sh_queue.sv */
// ----------------------------------------------------------------------------
// ac3sh_queue
// Short FIFO between the search front end and the decoder.
// ----------------------------------------------------------------------------
module ac3sh_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ac3sh_pkg::hdr_evt_t  wr_evt,
	output logic                 full,
	input  logic                 pop,
	output ac3sh_pkg::hdr_evt_t  head,
	output logic                 empty
);
	import ac3sh_pkg::*;

	localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	hdr_evt_t       mem_q [0:QDEPTH-1];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full  = count_q == (QAW+1)'(QDEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_evt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QAW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QAW+1)'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue write while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + (QAW+1)'(1))
		else $error("queue count did not advance on write");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW+1)'(QDEPTH)) else $error("queue count out of range");

endmodule

/* hdl/ac3sh_back.sv */
// ----------------------------------------------------------------------------
// ac3sh_back
// Header field decode into the registered report output.
// ----------------------------------------------------------------------------
module ac3sh_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ac3sh_pkg::hdr_evt_t  head,
	input  logic                 empty,
	output logic                 pop,
	ac3sh_out_if.source          hdr_ch
);
	import ac3sh_pkg::*;

	logic        valid_q;
	logic [1:0]  status_q;
	logic [15:0] offs_q;
	logic [19:0] stream_bps_q;
	logic [15:0] audio_hz_q;
	logic [11:0] frame_bytes_q;
	logic [2:0]  coding_mode_q;
	logic        lfe_q;
	logic        dsur_q;
	logic [2:0]  channels_q;

	logic        load;
	logic [4:0]  idx;
	logic [1:0]  half;
	logic [2:0]  acmod;
	logic        lfe;
	logic        dsur;
	logic [9:0]  kbps;
	logic [10:0] words;
	logic [19:0] stream_bps_d;
	logic [15:0] audio_hz_d;
	logic [11:0] frame_bytes_d;
	logic [2:0]  channels_d;
	logic        ok;

	assign load = !valid_q || hdr_ch.ready;
	assign pop  = load && !empty;

	always_comb begin
		idx          = head.b4[5:1];
		half         = half_shift(head.b5[6:3]);
		acmod        = head.b6[7:5];
		dsur         = (head.b6 & DSUR_MASK) == DSUR_CODE;
		lfe          = (head.b6 & lfe_mask(acmod)) != 8'd0;
		kbps         = rate_kbps(idx);
		words        = words_44k(idx) + 11'(head.b4[0]);
		stream_bps_d = rate_bps(idx) >> half;
		case (head.b4[7:6])
			FS_48K: begin
				audio_hz_d    = SR_48K >> half;
				frame_bytes_d = {kbps, 2'b00};
			end
			FS_44K: begin
				audio_hz_d    = SR_44K >> half;
				frame_bytes_d = {words, 1'b0};
			end
			default: begin
				audio_hz_d    = SR_32K >> half;
				frame_bytes_d = {kbps, 2'b00} + {1'b0, kbps, 1'b0};
			end
		endcase
		channels_d = (dsur ? DSUR_CH : mode_channels(acmod)) + 3'(lfe);
		ok         = head.status == ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q      <= head.status;
			offs_q        <= head.sync_offset;
			stream_bps_q  <= ok ? stream_bps_d : '0;
			audio_hz_q    <= ok ? audio_hz_d : '0;
			frame_bytes_q <= ok ? frame_bytes_d : '0;
			coding_mode_q <= ok ? acmod : '0;
			lfe_q         <= ok && lfe;
			dsur_q        <= ok && dsur;
			channels_q    <= ok ? channels_d : '0;
		end
	end

	assign hdr_ch.valid          = valid_q;
	assign hdr_ch.status         = status_q;
	assign hdr_ch.sync_offset    = offs_q;
	assign hdr_ch.stream_bps     = stream_bps_q;
	assign hdr_ch.audio_hz       = audio_hz_q;
	assign hdr_ch.frame_bytes    = frame_bytes_q;
	assign hdr_ch.coding_mode    = coding_mode_q;
	assign hdr_ch.has_lfe        = lfe_q;
	assign hdr_ch.dolby_surround = dsur_q;
	assign hdr_ch.channels       = channels_q;

endmodule

/* hdl/ac3_sync_header_finder.sv */
// ----------------------------------------------------------------------------
// ac3_sync_header_finder
// Finds and decodes the first AC-3 sync frame header of each byte buffer.
// ----------------------------------------------------------------------------
// Usage:
//   byte_ch takes one buffer byte per transaction; last_byte marks the final
//   byte and restarts the search for the next buffer.
//   hdr_ch gives at most one report per buffer: a decoded header, a bad
//   frame size or sample rate code, or not found at the buffer's last byte.
//   Only the first header whose bsid byte is below 0x60 is reported; bytes past
//   MAX_BUFFER in one buffer are not searched.
// Timing:
//   One byte per cycle while the event queue is not full. A report goes from
//   the byte that causes it into the event queue, then through the table
//   decode into the output register before it is valid on hdr_ch.
//   While hdr_ch stalls, bytes that cause no report keep flowing; byte_ch
//   drops ready only when the two-entry event queue is full.
// Reset:
//   arst_n clears the search position, the reported flag, the queue and
//   the output valid. No clearing pass is needed.
// ----------------------------------------------------------------------------
module ac3_sync_header_finder #(
	parameter int MAX_BUFFER = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	ac3sh_in_if.sink    byte_ch,
	ac3sh_out_if.source hdr_ch
);
	import ac3sh_pkg::*;

	logic     push;
	logic     full;
	logic     pop;
	logic     empty;
	hdr_evt_t wr_evt;
	hdr_evt_t head;

	ac3sh_front #(
		.MAX_BUFFER (MAX_BUFFER)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.full    (full),
		.push    (push),
		.evt     (wr_evt)
	);

	ac3sh_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_evt (wr_evt),
		.full   (full),
		.pop    (pop),
		.head   (head),
		.empty  (empty)
	);

	ac3sh_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.hdr_ch (hdr_ch)
	);

endmodule
